@@ hw/rtl/sst_pkg.sv @@
// Package for the sortable stack: word width, depth default, action and
// status codes, and the result record.
// No dependencies.
package sst_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 64;
   localparam int COUNT_OUT_W   = 7;

   localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;

   typedef enum logic [1:0] {
      ACT_PUSH = 2'd0,
      ACT_POP  = 2'd1,
      ACT_SORT = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      status_type               status;
      logic [COUNT_OUT_W-1:0]   entry_count;
      logic [DATA_W-1:0]        top_value;
      logic [DATA_W-1:0]        popped_value;
   } rsp_type;

endpackage

@@ hw/rtl/sst_ram.sv @@
// Generic RAM with one write port and one read port, registered read data.
// No dependencies.
module sst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sortable_stack.sv @@
// Top level of the sortable stack: sequencer, count and top registers,
// result register. Depends on sst_pkg and sst_ram.
//
//   Channel    Direction  Handshake               Carries
//   req_*      in         req_tvalid/req_tready   tuser: action; tdata: push value
//   rsp_*      out        rsp_tvalid/rsp_tready   tuser: status; tdata: popped,
//                                                 top, entry count
//
// A push, a pop on an empty stack or one that leaves it empty, a sort of fewer
// than two entries and the unused action code complete in the cycle they are
// accepted. A pop that leaves entries goes through ST_POP_RD, since the new
// top comes from the entry RAM, whose read data is registered. A sort of n
// entries is an insertion sort through the single RAM read port; its run time
// grows with n and with the number of pairs of entries out of order.
// Reset clears the count and the sequencer; the entry RAM needs no clearing.
// A finished result waits in the output register; one more result can be
// held internally, after which the block stops taking items until the
// output drains.
module sortable_stack #(
   parameter int DEPTH = sst_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] popped_value, [63:32] top_value,
                                    // [70:64] entry_count, [71] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DW    = sst_pkg::DATA_W;
   localparam int OW    = sst_pkg::COUNT_OUT_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_SORT_LOAD,
      ST_SORT_CMP,
      ST_SORT_PLACE,
      ST_SORT_TOP,
      ST_SORT_FIN,
      ST_DONE
   } state_type;

   // The reported count is the stored count reduced to the output width.
   function automatic logic [OW-1:0] cnt_out(input logic [CNT_W-1:0] c);
      logic [CNT_W+OW-1:0] ext;
      ext = {{OW{1'b0}}, c};
      return ext[OW-1:0];
   endfunction

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [DW-1:0]    top_ff;
   logic [AW-1:0]    i_ff;
   logic [AW-1:0]    j_ff;
   logic [DW-1:0]    w_ff;
   sst_pkg::rsp_type res_ff;
   sst_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;

   logic                   accept;
   sst_pkg::action_type    action;
   logic                   rsp_free;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [DW-1:0]          wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [DW-1:0]          rd_data;
   logic                   fin;
   sst_pkg::rsp_type       fin_res;
   logic                   less;
   logic                   last_i;
   logic [CNT_W-1:0]       i_plus;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign action     = sst_pkg::action_type'(req_tuser);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign less       = $signed(w_ff) < $signed(rd_data);
   assign i_plus     = CNT_W'(i_ff) + 1'b1;
   assign last_i     = (i_plus == count_ff);

   sst_ram #(
      .WIDTH(DW),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // RAM port control and the result that completes in this cycle, if any.
   // The sort never reads an entry in the cycle it writes it, so no
   // forwarding path is needed.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = j_ff;
      wr_data = w_ff;
      rd_en   = 1'b0;
      rd_addr = AW'(i_plus);
      fin     = 1'b0;
      fin_res = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            fin_res.popped_value = sst_pkg::MOST_NEG;
            fin_res.top_value    = top_ff;
            fin_res.entry_count  = cnt_out(count_ff);
            fin_res.status       = sst_pkg::STS_OK;
            if (accept) begin
               unique case (action)
                  sst_pkg::ACT_PUSH: begin
                     fin = 1'b1;
                     if (count_ff < FULL_COUNT) begin
                        wr_en               = 1'b1;
                        wr_addr             = AW'(count_ff);
                        wr_data             = req_tdata;
                        fin_res.top_value   = req_tdata;
                        fin_res.entry_count = cnt_out(count_ff + 1'b1);
                     end else begin
                        fin_res.status = sst_pkg::STS_FULL;
                     end
                  end
                  sst_pkg::ACT_POP: begin
                     if (count_ff == '0) begin
                        fin            = 1'b1;
                        fin_res.status = sst_pkg::STS_EMPTY;
                     end else if (count_ff == CNT_W'(1)) begin
                        fin                  = 1'b1;
                        fin_res.popped_value = top_ff;
                        fin_res.top_value    = sst_pkg::MOST_NEG;
                        fin_res.entry_count  = '0;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(count_ff - 2'd2);
                     end
                  end
                  sst_pkg::ACT_SORT: begin
                     if (count_ff < CNT_W'(2)) begin
                        fin = 1'b1;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(1);
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_POP_RD: begin
            fin               = 1'b1;
            fin_res.top_value = rd_data;
         end
         ST_SORT_LOAD: begin
            rd_en   = 1'b1;
            rd_addr = i_ff - 1'b1;
         end
         ST_SORT_CMP: begin
            wr_en = 1'b1;
            if (less) begin
               // Shift the larger entry up one place and look further down.
               wr_data = rd_data;
               if (j_ff != AW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = j_ff - 2'd2;
               end
            end else begin
               wr_data = w_ff;
               rd_en   = !last_i;
            end
         end
         ST_SORT_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            rd_en   = !last_i;
         end
         ST_SORT_TOP: begin
            rd_en   = 1'b1;
            rd_addr = AW'(count_ff - 1'b1);
         end
         ST_SORT_FIN: begin
            fin               = 1'b1;
            fin_res.top_value = rd_data;
         end
         ST_DONE: begin
            fin = 1'b0;
         end
         default: begin
            fin = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         top_ff       <= sst_pkg::MOST_NEG;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (action)
                     sst_pkg::ACT_PUSH: begin
                        if (count_ff < FULL_COUNT) begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     sst_pkg::ACT_POP: begin
                        if (count_ff != '0) begin
                           count_ff <= count_ff - 1'b1;
                        end
                        if (count_ff >= CNT_W'(2)) begin
                           res_ff.popped_value <= top_ff;
                           res_ff.entry_count  <= cnt_out(count_ff - 1'b1);
                           res_ff.status       <= sst_pkg::STS_OK;
                           state_ff            <= ST_POP_RD;
                        end
                     end
                     sst_pkg::ACT_SORT: begin
                        if (count_ff >= CNT_W'(2)) begin
                           i_ff                <= AW'(1);
                           res_ff.popped_value <= sst_pkg::MOST_NEG;
                           res_ff.entry_count  <= cnt_out(count_ff);
                           res_ff.status       <= sst_pkg::STS_OK;
                           state_ff            <= ST_SORT_LOAD;
                        end
                     end
                     default: begin
                        // The unused code changes nothing; its result is
                        // completed below.
                     end
                  endcase
               end
            end
            ST_SORT_LOAD: begin
               w_ff     <= rd_data;
               j_ff     <= i_ff;
               state_ff <= ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
               if (less) begin
                  j_ff <= j_ff - 1'b1;
                  if (j_ff == AW'(1)) begin
                     state_ff <= ST_SORT_PLACE;
                  end
               end else if (last_i) begin
                  state_ff <= ST_SORT_TOP;
               end else begin
                  i_ff     <= AW'(i_plus);
                  state_ff <= ST_SORT_LOAD;
               end
            end
            ST_SORT_PLACE: begin
               if (last_i) begin
                  state_ff <= ST_SORT_TOP;
               end else begin
                  i_ff     <= AW'(i_plus);
                  state_ff <= ST_SORT_LOAD;
               end
            end
            ST_SORT_TOP: begin
               state_ff <= ST_SORT_FIN;
            end
            ST_DONE: begin
               if (rsp_tready) begin
                  rsp_ff   <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               // The pop and sort finishing states always complete a result
               // and leave through the result logic below.
            end
         endcase
         // A completed result goes straight out when the output register is
         // free, otherwise it waits in the holding register.
         if (fin) begin
            top_ff <= fin_res.top_value;
            if (rsp_free) begin
               rsp_ff   <= fin_res;
               state_ff <= ST_IDLE;
            end else begin
               res_ff   <= fin_res;
               state_ff <= ST_DONE;
            end
         end
         // The output register stays full while a new or held result moves
         // in, and empties when its item is taken with nothing behind it.
         if ((fin && rsp_free) || (state_ff == ST_DONE && rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.entry_count, rsp_ff.top_value, rsp_ff.popped_value};
   assign rsp_tuser  = rsp_ff.status;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("stack count above depth");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (top_ff == sst_pkg::MOST_NEG))
      else $error("empty stack with a live top word");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && action == sst_pkg::ACT_PUSH && count_ff < FULL_COUNT)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("accepted push did not grow the stack");

   a_sort_write_range: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == ST_SORT_CMP || state_ff == ST_SORT_PLACE))
      |-> (CNT_W'(wr_addr) < count_ff))
      else $error("sort wrote above the stored entries");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> rsp_valid_ff)
      else $error("held result while the output register is empty");

endmodule
